>>> rtl/signed_alu_with_bitstring_width_macros.svh
// assertion macros for the signed alu blocks
// no dependencies; the design clock must be named clock
`ifndef SIGNED_ALU_WITH_BITSTRING_WIDTH_MACROS_SVH
`define SIGNED_ALU_WITH_BITSTRING_WIDTH_MACROS_SVH
`ifndef SYNTHESIS
`define SAWBW_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SAWBW_ASSERT_ANY(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SAWBW_ASSERT(lbl, prop, msg)
`define SAWBW_ASSERT_ANY(lbl, prop, msg)
`endif
`endif

>>> rtl/sawbw_pkg.sv
// shared types and constants for the signed alu with bitstring operands
// no dependencies
package sawbw_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int SHIFT_BITS  = 6;

   typedef enum logic [3:0] {
      OP_SHR, OP_SHL, OP_AND, OP_OR, OP_XOR, OP_NOT,
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_TOBITS, OP_FROMBITS
   } op_type;

   typedef enum logic [1:0] {BK_RUN, BK_MUL, BK_DIV} bk_state_type;

   typedef struct packed {
      logic [3:0]         kind;
      logic signed [63:0] operand_a;
      logic               a_is_bits;
      logic [6:0]         a_len;
      logic signed [63:0] operand_b;
      logic               b_is_bits;
      logic [6:0]         b_len;
   } req_type;

   typedef struct packed {
      logic signed [63:0] result_value;
      logic [6:0]         result_width;
      logic               result_is_bits;
      logic               div_error;
   } rsp_type;

   // decoded word between front and back
   typedef struct packed {
      logic [3:0]            kind;
      logic [63:0]           a;
      logic [63:0]           b;
      logic [SHIFT_BITS-1:0] sh;
      logic                  rbits;
   } item_type;

endpackage

>>> rtl/sawbw_front.sv
// front end: operand decoding and classification of each word
// depends on sawbw_pkg
module sawbw_front #(
   parameter int DATA_WIDTH = 64
) (
   input  sawbw_pkg::req_type  req_word,
   output sawbw_pkg::item_type item
);
   import sawbw_pkg::*;

   function automatic logic [63:0] decode(logic [63:0] v, logic is_bits, logic [6:0] len);
      logic [6:0]  l;
      logic [63:0] r;
      logic        sgn;
      l = len;
      if (l == 7'd0) l = 7'd1;
      if (l > 7'(DATA_WIDTH)) l = 7'(DATA_WIDTH);
      if (!is_bits) l = 7'(DATA_WIDTH);
      sgn = v[6'(l - 7'd1)];
      for (int i = 0; i < 64; i++) r[i] = (7'(i) < l) ? v[i] : sgn;
      return r;
   endfunction

   logic [63:0] a_dec;
   logic [63:0] b_dec;

   assign a_dec = decode(req_word.operand_a, req_word.a_is_bits, req_word.a_len);
   assign b_dec = decode(req_word.operand_b, req_word.b_is_bits, req_word.b_len);

   always_comb begin
      item.kind = req_word.kind;
      item.a    = a_dec;
      item.b    = b_dec;
      // negative counts give zero, large counts saturate
      priority if (b_dec[63]) begin
         item.sh = '0;
      end else if (b_dec > 64'(DATA_WIDTH - 1)) begin
         item.sh = SHIFT_BITS'(DATA_WIDTH - 1);
      end else begin
         item.sh = b_dec[SHIFT_BITS-1:0];
      end
      unique case (op_type'(req_word.kind))
         OP_SHR, OP_SHL, OP_NOT: item.rbits = req_word.a_is_bits;
         OP_AND, OP_OR, OP_XOR:  item.rbits = req_word.a_is_bits | req_word.b_is_bits;
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_TOBITS: item.rbits = 1'b1;
         default:                item.rbits = 1'b0;
      endcase
   end

endmodule

>>> rtl/sawbw_queue.sv
// short queue of decoded words between front and back
// depends on sawbw_pkg and the macro header
`include "signed_alu_with_bitstring_width_macros.svh"
module sawbw_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sawbw_pkg::item_type push_item,
   input  logic                pop,
   output sawbw_pkg::item_type head_item,
   output logic                not_empty,
   output logic                full
);
   import sawbw_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   item_type        slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_item;
   end

   assign head_item = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CW'(QUEUE_DEPTH));

   `SAWBW_ASSERT(a_no_push_full, full |-> !push, "push into full queue")
   `SAWBW_ASSERT(a_no_pop_empty, pop |-> not_empty, "pop from empty queue")
   `SAWBW_ASSERT_ANY(a_count_bound, reset || (count_ff <= CW'(QUEUE_DEPTH)), "queue count out of range")

endmodule

>>> rtl/sawbw_back.sv
// back end: executes decoded words, shared multiplier and radix-2 divider,
// then the width stage; depends on sawbw_pkg and the macro header
`include "signed_alu_with_bitstring_width_macros.svh"
module sawbw_back #(
   parameter int DATA_WIDTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  sawbw_pkg::item_type head_item,
   input  logic                not_empty,
   output logic                pop,
   output logic                rsp_valid,
   output sawbw_pkg::rsp_type  rsp_word
);
   import sawbw_pkg::*;

   localparam int W    = DATA_WIDTH;
   localparam int HALF = (DATA_WIDTH + 1) / 2;
   localparam int PRW  = 2 * HALF;
   localparam int DCW  = $clog2(DATA_WIDTH);

   function automatic logic [6:0] min_width(logic [W-1:0] v);
      logic [W-1:0] x;
      logic [6:0]   n;
      x = v[W-1] ? ~v : v;
      n = 7'd1;
      for (int i = 0; i < W; i++) if (x[i]) n = 7'(i + 2);
      return n;
   endfunction

   bk_state_type   state_ff, state_in;
   logic [W-1:0]   ma_ff, ma_in;
   logic [W-1:0]   mb_ff, mb_in;
   logic [W-1:0]   rem_ff, rem_in;
   logic [W-1:0]   acc_ff, acc_in;
   logic [PRW-1:0] prod_ff, prod_in;
   logic [1:0]     mcnt_ff, mcnt_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   logic           neg_ff, neg_in;
   logic           res_valid_ff, res_valid_in;
   logic [W-1:0]   res_value_ff, res_value_in;
   logic           res_rbits_ff, res_rbits_in;
   logic           res_err_ff, res_err_in;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff;

   logic [W-1:0]   aw, bw;
   logic [HALF-1:0] m_x, m_y;
   logic [W-1:0]   term;
   logic [W:0]     rem_sh, diff;
   logic           ge;

   assign aw = head_item.a[W-1:0];
   assign bw = head_item.b[W-1:0];

   always_comb begin
      state_in     = state_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      rem_in       = rem_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      mcnt_in      = mcnt_ff;
      dcnt_in      = dcnt_ff;
      neg_in       = neg_ff;
      pop          = 1'b0;
      res_valid_in = 1'b0;
      res_value_in = res_value_ff;
      res_rbits_in = res_rbits_ff;
      res_err_in   = 1'b0;
      m_x          = '0;
      m_y          = '0;
      term         = '0;
      rem_sh       = {rem_ff, ma_ff[W-1]};
      diff         = rem_sh - {1'b0, mb_ff};
      ge           = !diff[W];
      unique case (state_ff)
         BK_RUN: begin
            if (not_empty) begin
               pop          = 1'b1;
               res_rbits_in = head_item.rbits;
               res_valid_in = 1'b1;
               unique case (op_type'(head_item.kind))
                  OP_SHR:    res_value_in = W'($signed(aw) >>> head_item.sh);
                  OP_SHL:    res_value_in = W'(aw << head_item.sh);
                  OP_AND:    res_value_in = aw & bw;
                  OP_OR:     res_value_in = aw | bw;
                  OP_XOR:    res_value_in = aw ^ bw;
                  OP_NOT:    res_value_in = ~aw;
                  OP_ADD:    res_value_in = aw + bw;
                  OP_SUB:    res_value_in = aw - bw;
                  OP_TOBITS, OP_FROMBITS: res_value_in = aw;
                  OP_MUL: begin
                     res_valid_in = 1'b0;
                     ma_in        = aw;
                     mb_in        = bw;
                     mcnt_in      = '0;
                     state_in     = BK_MUL;
                  end
                  OP_DIV: begin
                     if (bw == '0) begin
                        res_value_in = '0;
                        res_err_in   = 1'b1;
                     end else begin
                        res_valid_in = 1'b0;
                        ma_in        = aw[W-1] ? -aw : aw;
                        mb_in        = bw[W-1] ? -bw : bw;
                        neg_in       = aw[W-1] ^ bw[W-1];
                        rem_in       = '0;
                        dcnt_in      = '0;
                        state_in     = BK_DIV;
                     end
                  end
                  default:   res_value_in = '0;
               endcase
            end
         end
         BK_MUL: begin
            // one partial product per cycle, added in the next cycle
            unique case (mcnt_ff)
               2'd0: begin
                  m_x = ma_ff[HALF-1:0];
                  m_y = mb_ff[HALF-1:0];
               end
               2'd1: begin
                  m_x = ma_ff[HALF-1:0];
                  m_y = HALF'(mb_ff[W-1:HALF]);
               end
               2'd2: begin
                  m_x = HALF'(ma_ff[W-1:HALF]);
                  m_y = mb_ff[HALF-1:0];
               end
               default: begin
                  m_x = '0;
                  m_y = '0;
               end
            endcase
            prod_in = m_x * m_y;
            term = (mcnt_ff == 2'd1) ? W'(prod_ff) : W'({prod_ff, {HALF{1'b0}}});
            if (mcnt_ff == 2'd1) begin
               acc_in = term;
            end else if (mcnt_ff != 2'd0) begin
               acc_in = acc_ff + term;
            end
            mcnt_in = mcnt_ff + 2'd1;
            if (mcnt_ff == 2'd3) begin
               res_valid_in = 1'b1;
               res_value_in = acc_in;
               state_in     = BK_RUN;
            end
         end
         BK_DIV: begin
            // restoring division, one quotient bit per cycle
            rem_in  = ge ? diff[W-1:0] : rem_sh[W-1:0];
            ma_in   = {ma_ff[W-2:0], ge};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCW'(W - 1)) begin
               res_valid_in = 1'b1;
               res_value_in = neg_ff ? -ma_in : ma_in;
               state_in     = BK_RUN;
            end
         end
         default: state_in = BK_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_RUN;
         res_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         res_valid_ff <= res_valid_in;
         rsp_valid_ff <= res_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      ma_ff        <= ma_in;
      mb_ff        <= mb_in;
      rem_ff       <= rem_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      mcnt_ff      <= mcnt_in;
      dcnt_ff      <= dcnt_in;
      neg_ff       <= neg_in;
      res_value_ff <= res_value_in;
      res_rbits_ff <= res_rbits_in;
      res_err_ff   <= res_err_in;
      rsp_ff.result_value   <= 64'($signed(res_value_ff));
      rsp_ff.result_width   <= min_width(res_value_ff);
      rsp_ff.result_is_bits <= res_rbits_ff;
      rsp_ff.div_error      <= res_err_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   `SAWBW_ASSERT(a_rsp_follows_res, rsp_valid_ff |-> $past(res_valid_ff), "result without stage")
   `SAWBW_ASSERT(a_no_pop_busy, (state_ff != BK_RUN) |-> !pop, "pop while unit busy")
   `SAWBW_ASSERT(a_err_is_bits, (res_valid_ff && res_err_ff) |-> res_rbits_ff, "error not bits")

endmodule

>>> rtl/signed_alu_with_bitstring_width.sv
// a start word is written into the queue, popped into the back end result register
// and registered again in the width stage as rsp_valid; mul and a nonzero divide first
// iterate (one quotient bit per cycle); one word per cycle for simple ops while
// busy is low; the 4-entry queue keeps taking words while mul or divide iterates
// reset: synchronous active high, empties the queue and idles the back end
// results cannot be stalled: each rsp_valid strobe lasts one cycle
module signed_alu_with_bitstring_width #(
   parameter int DATA_WIDTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  sawbw_pkg::req_type req_word,
   output logic               rsp_valid,
   output sawbw_pkg::rsp_type rsp_word
);
   import sawbw_pkg::*;

   // decoded word from the front end
   item_type front_item;
   // word at the head of the queue
   item_type head_item;
   logic     q_not_empty;
   logic     q_full;
   logic     q_pop;
   logic     q_push;

   // a word is taken whenever the queue has room
   assign q_push = start & ~busy;
   assign busy   = q_full;

   // front: sign-extends bit patterns, clamps the shift count, picks result form
   sawbw_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .req_word (req_word),
      .item     (front_item)
   );

   // queue: lets the front keep accepting while mul or divide iterates
   sawbw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .pop       (q_pop),
      .head_item (head_item),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   // back: alu, shared multiplier, divider, minimal width stage
   sawbw_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_item (head_item),
      .not_empty (q_not_empty),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule
